// ===== rtl/tiled_blit_rectangle_walker_core_defines.svh =====
// Assertion macros shared by the checker of the tiled blit rectangle walker.
// No dependencies; each macro expects i_clk and i_rst_n in scope.
`ifndef TILED_BLIT_RECTANGLE_WALKER_CORE_DEFINES_SVH
`define TILED_BLIT_RECTANGLE_WALKER_CORE_DEFINES_SVH

// Same-cycle implication, quiet while reset is held.
`define TBRW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is held.
`define TBRW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check the cycle after reset is held.
`define TBRW_ASSERT_RESET(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tbrw_pkg.sv =====
// Shared types and constants of the tiled blit rectangle walker.
// No dependencies.
package tbrw_pkg;

    localparam int COORD_BITS = 12;
    localparam int TILE_BITS  = COORD_BITS + 8;
    localparam int SCALE_BITS = 16;
    localparam int POS_BITS   = 16;
    localparam int NUM_BITS   = 2 * COORD_BITS;
    localparam int DIV_CNT_W  = $clog2(NUM_BITS);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = SCALE_BITS;
    localparam int JOB_DEPTH  = 2;
    localparam int JOB_PTR_W  = $clog2(JOB_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_W = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_H = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Q8  = 3'd4;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_NEXT  = 1'b1;

    localparam logic [SCALE_BITS-1:0] SCALE_RESET = 16'h0100;

    // One tile as the front hands it to the back.
    typedef struct packed {
        logic                  valid;
        logic                  last;
        logic [POS_BITS-1:0]   place_x;
        logic [POS_BITS-1:0]   place_y;
        logic [COORD_BITS-1:0] place_w;
        logic [COORD_BITS-1:0] place_h;
        logic [TILE_BITS-1:0]  tile_w;
        logic [TILE_BITS-1:0]  tile_h;
    } t_job;

    // One finished result item.
    typedef struct packed {
        logic                  tile_valid;
        logic [COORD_BITS-1:0] cut_x;
        logic [COORD_BITS-1:0] cut_y;
        logic [COORD_BITS-1:0] cut_w;
        logic [COORD_BITS-1:0] cut_h;
        logic [POS_BITS-1:0]   place_x;
        logic [POS_BITS-1:0]   place_y;
        logic [COORD_BITS-1:0] place_w;
        logic [COORD_BITS-1:0] place_h;
        logic                  last_tile;
    } t_result;

endpackage

// ===== rtl/tbrw_front.sv =====
// Front of the walker: accepts requests, latches the area and tile size,
// walks the offsets and emits one job per request. Depends on tbrw_pkg.
module tbrw_front
    import tbrw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic                  i_req_type,
    input  logic [POS_BITS-1:0]   i_area_x,
    input  logic [POS_BITS-1:0]   i_area_y,
    input  logic [COORD_BITS-1:0] i_area_w,
    input  logic [COORD_BITS-1:0] i_area_h,
    input  logic [COORD_BITS-1:0] i_pattern_w,
    input  logic [COORD_BITS-1:0] i_pattern_h,
    input  logic [SCALE_BITS-1:0] i_scale,
    output logic                  o_job_push,
    output t_job                  o_job,
    input  logic                  i_job_full
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MULW = 2'd1;
    localparam logic [1:0] F_MULH = 2'd2;
    localparam logic [1:0] F_EMIT = 2'd3;

    logic [1:0]            r_state, n_state;
    logic                  r_walking, n_walking;
    logic [POS_BITS-1:0]   r_area_x, r_area_y;
    logic [COORD_BITS-1:0] r_area_w, r_area_h;
    logic [TILE_BITS-1:0]  r_tile_w, r_tile_h;
    logic [COORD_BITS-1:0] r_off_x, n_off_x, r_off_y, n_off_y;

    logic [COORD_BITS+SCALE_BITS-1:0] prod;
    logic [COORD_BITS-1:0]            mul_a;
    logic [COORD_BITS-1:0]            rem_w, rem_h, pw, ph;
    logic [TILE_BITS:0]               nx, ny;
    logic                             last;

    assign o_full = (r_state != F_IDLE);

    // One multiplier, shared by width and height.
    assign mul_a = (r_state == F_MULW) ? i_pattern_w : i_pattern_h;
    assign prod  = mul_a * i_scale;

    assign rem_w = r_area_w - r_off_x;
    assign rem_h = r_area_h - r_off_y;
    assign pw    = (r_tile_w < {8'd0, rem_w}) ? r_tile_w[COORD_BITS-1:0] : rem_w;
    assign ph    = (r_tile_h < {8'd0, rem_h}) ? r_tile_h[COORD_BITS-1:0] : rem_h;
    assign ny    = {1'b0, r_tile_h} + (TILE_BITS+1)'(r_off_y);
    assign nx    = {1'b0, r_tile_w} + (TILE_BITS+1)'(r_off_x);

    always_comb begin
        n_state   = r_state;
        n_walking = r_walking;
        n_off_x   = r_off_x;
        n_off_y   = r_off_y;
        last      = 1'b0;
        o_job_push = 1'b0;
        o_job      = '0;
        unique case (r_state)
            F_IDLE: begin
                if (i_push) begin
                    n_state = (i_req_type == REQ_START) ? F_MULW : F_EMIT;
                end
            end
            F_MULW: begin
                n_state = F_MULH;
                n_off_x = '0;
                n_off_y = '0;
            end
            F_MULH: begin
                n_state   = F_EMIT;
                n_walking = (r_tile_w != '0) && (prod[COORD_BITS+15:8] != '0) &&
                            (r_area_w != '0) && (r_area_h != '0);
            end
            F_EMIT: begin
                if (!i_job_full) begin
                    o_job_push = 1'b1;
                    n_state    = F_IDLE;
                    if (r_walking) begin
                        // Column-major: step down first, then to the next column.
                        if (ny < (TILE_BITS+1)'(r_area_h)) begin
                            n_off_y = ny[COORD_BITS-1:0];
                        end else begin
                            n_off_y = '0;
                            if (nx < (TILE_BITS+1)'(r_area_w)) begin
                                n_off_x = nx[COORD_BITS-1:0];
                            end else begin
                                n_off_x   = '0;
                                n_walking = 1'b0;
                                last      = 1'b1;
                            end
                        end
                        o_job.valid   = 1'b1;
                        o_job.last    = last;
                        o_job.place_x = r_area_x + POS_BITS'(r_off_x);
                        o_job.place_y = r_area_y + POS_BITS'(r_off_y);
                        o_job.place_w = pw;
                        o_job.place_h = ph;
                        o_job.tile_w  = r_tile_w;
                        o_job.tile_h  = r_tile_h;
                    end
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= F_IDLE;
            r_walking <= 1'b0;
            r_area_x  <= '0;
            r_area_y  <= '0;
            r_area_w  <= '0;
            r_area_h  <= '0;
            r_tile_w  <= '0;
            r_tile_h  <= '0;
            r_off_x   <= '0;
            r_off_y   <= '0;
        end else begin
            r_state   <= n_state;
            r_walking <= n_walking;
            r_off_x   <= n_off_x;
            r_off_y   <= n_off_y;
            if (r_state == F_IDLE && i_push && i_req_type == REQ_START) begin
                r_area_x <= i_area_x;
                r_area_y <= i_area_y;
                r_area_w <= i_area_w;
                r_area_h <= i_area_h;
            end
            if (r_state == F_MULW) begin
                r_tile_w <= prod[COORD_BITS+15:8];
            end
            if (r_state == F_MULH) begin
                r_tile_h <= prod[COORD_BITS+15:8];
            end
        end
    end

endmodule

// ===== rtl/tbrw_job_fifo.sv =====
// Short queue of jobs between the front and the back of the walker.
// Depends on tbrw_pkg.
module tbrw_job_fifo
    import tbrw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    t_job                 r_slot [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] r_wr, r_rd;
    logic [JOB_PTR_W:0]   r_count;
    logic                 do_push, do_pop;

    assign o_full  = (r_count == (JOB_PTR_W+1)'(JOB_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_slot[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == JOB_PTR_W'(JOB_DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == JOB_PTR_W'(JOB_DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + (JOB_PTR_W+1)'(do_push) - (JOB_PTR_W+1)'(do_pop);
        end
    end

endmodule

// ===== rtl/tbrw_back.sv =====
// Back of the walker: scales the source size of each job with a shared
// radix-2 divider and holds the finished result. Depends on tbrw_pkg.
module tbrw_back
    import tbrw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [COORD_BITS-1:0] i_pattern_x,
    input  logic [COORD_BITS-1:0] i_pattern_y,
    input  logic [COORD_BITS-1:0] i_pattern_w,
    input  logic [COORD_BITS-1:0] i_pattern_h,
    input  t_job                  i_job,
    input  logic                  i_job_empty,
    output logic                  o_job_pop,
    input  logic                  i_pop,
    output logic                  o_empty,
    output t_result               o_result
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_MUL  = 2'd1;
    localparam logic [1:0] B_DIV  = 2'd2;
    localparam logic [1:0] B_DONE = 2'd3;

    logic [1:0]            r_state;
    logic                  r_dim;
    t_job                  r_job;
    logic [NUM_BITS-1:0]   r_num;
    logic [TILE_BITS-1:0]  r_rem;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [COORD_BITS-1:0] r_cut_w, r_cut_h;
    logic                  r_out_valid;
    t_result               r_out;

    logic [COORD_BITS-1:0] part, pat;
    logic [TILE_BITS-1:0]  den;
    logic [NUM_BITS-1:0]   prod;
    logic [TILE_BITS:0]    trial, diff;
    logic                  ge, load_out;

    assign part  = r_dim ? r_job.place_h : r_job.place_w;
    assign pat   = r_dim ? i_pattern_h : i_pattern_w;
    assign den   = r_dim ? r_job.tile_h : r_job.tile_w;
    assign prod  = part * pat;
    assign trial = {r_rem, r_num[NUM_BITS-1]};
    assign diff  = trial - {1'b0, den};
    assign ge    = (trial >= {1'b0, den});

    assign o_job_pop = (r_state == B_IDLE) && !i_job_empty;
    assign load_out  = (r_state == B_DONE) && (!r_out_valid || i_pop);
    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_dim       <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (!i_job_empty) begin
                        r_state <= B_MUL;
                        r_dim   <= 1'b0;
                    end
                end
                B_MUL: begin
                    r_cnt <= '0;
                    if (!r_job.valid) begin
                        r_state <= B_DONE;
                    end else if ({8'd0, part} == den) begin
                        // Full tile: the source size passes unscaled.
                        r_dim   <= 1'b1;
                        r_state <= r_dim ? B_DONE : B_MUL;
                    end else begin
                        r_state <= B_DIV;
                    end
                end
                B_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_CNT_W'(NUM_BITS-1)) begin
                        r_dim   <= 1'b1;
                        r_state <= r_dim ? B_DONE : B_MUL;
                    end
                end
                B_DONE: begin
                    if (load_out) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath: job, divider and result registers.
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
        end
        if (r_state == B_MUL) begin
            r_num <= prod;
            r_rem <= '0;
            if (!r_job.valid) begin
                r_cut_w <= '0;
                r_cut_h <= '0;
            end else if ({8'd0, part} == den) begin
                if (r_dim) begin
                    r_cut_h <= pat;
                end else begin
                    r_cut_w <= pat;
                end
            end
        end
        if (r_state == B_DIV) begin
            r_rem <= ge ? diff[TILE_BITS-1:0] : trial[TILE_BITS-1:0];
            r_num <= {r_num[NUM_BITS-2:0], ge};
            if (r_cnt == DIV_CNT_W'(NUM_BITS-1)) begin
                if (r_dim) begin
                    r_cut_h <= {r_num[COORD_BITS-2:0], ge};
                end else begin
                    r_cut_w <= {r_num[COORD_BITS-2:0], ge};
                end
            end
        end
        if (load_out) begin
            r_out.tile_valid <= r_job.valid;
            r_out.cut_x      <= r_job.valid ? i_pattern_x : '0;
            r_out.cut_y      <= r_job.valid ? i_pattern_y : '0;
            r_out.cut_w      <= r_cut_w;
            r_out.cut_h      <= r_cut_h;
            r_out.place_x    <= r_job.place_x;
            r_out.place_y    <= r_job.place_y;
            r_out.place_w    <= r_job.place_w;
            r_out.place_h    <= r_job.place_h;
            r_out.last_tile  <= r_job.last;
        end
    end

endmodule

// ===== rtl/tiled_blit_rectangle_walker_core.sv =====
// Top level of the tiled blit rectangle walker: configuration registers,
// front, job queue and back. Depends on tbrw_pkg and the three submodules.
//
// Use: write pattern_x/y/w/h and scale_q8 through i_cfg_we/i_cfg_idx/i_cfg_data
// while the block is idle (indexes 0 to 4, other indexes are dropped).
// Push a start request (req_type 0) with the destination rectangle, then push
// next requests (req_type 1); each request gives exactly one result item on
// the output queue, in request order. A result with tile_valid low marks the
// end of the walk or an empty one; all its other fields read zero.
// Input side: an item is taken when push is high and full is low. The front
// takes one item at a time: full stays high through states MULW, MULH and
// EMIT on a start, through EMIT on a next, and while the job queue is full.
// Output side: the result shows while empty is low and leaves on pop.
// The back takes one job at a time: per dimension it multiplies and, if the
// tile is clipped there, runs the shared radix-2 divider; a full tile or an
// empty result skips the divider. The front can accept new requests while
// the back is still busy with earlier ones.
// A two-entry job queue and the result register let the front run ahead
// while the receiver stalls; a stalled receiver holds its result as it is.
// Reset (synchronous, active low) clears the walk, empties both queues and
// loads the configuration reset values (scale 1.0, all else zero).
module tiled_blit_rectangle_walker_core
    import tbrw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic                  i_req_type,
    input  logic [POS_BITS-1:0]   i_area_x,
    input  logic [POS_BITS-1:0]   i_area_y,
    input  logic [COORD_BITS-1:0] i_area_w,
    input  logic [COORD_BITS-1:0] i_area_h,
    output logic                  empty,
    input  logic                  pop,
    output logic                  o_tile_valid,
    output logic [COORD_BITS-1:0] o_cut_x,
    output logic [COORD_BITS-1:0] o_cut_y,
    output logic [COORD_BITS-1:0] o_cut_w,
    output logic [COORD_BITS-1:0] o_cut_h,
    output logic [POS_BITS-1:0]   o_place_x,
    output logic [POS_BITS-1:0]   o_place_y,
    output logic [COORD_BITS-1:0] o_place_w,
    output logic [COORD_BITS-1:0] o_place_h,
    output logic                  o_last_tile
);

    logic [COORD_BITS-1:0] r_pattern_x, r_pattern_y, r_pattern_w, r_pattern_h;
    logic [SCALE_BITS-1:0] r_scale;

    logic    job_push, job_full, job_pop, job_empty;
    t_job    job_in, job_out;
    t_result result;

    // Configuration registers; write them only while the block is idle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_x <= '0;
            r_pattern_y <= '0;
            r_pattern_w <= '0;
            r_pattern_h <= '0;
            r_scale     <= SCALE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PATTERN_X: r_pattern_x <= i_cfg_data[COORD_BITS-1:0];
                CFG_PATTERN_Y: r_pattern_y <= i_cfg_data[COORD_BITS-1:0];
                CFG_PATTERN_W: r_pattern_w <= i_cfg_data[COORD_BITS-1:0];
                CFG_PATTERN_H: r_pattern_h <= i_cfg_data[COORD_BITS-1:0];
                CFG_SCALE_Q8:  r_scale     <= i_cfg_data[SCALE_BITS-1:0];
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    // Front: classify the request, walk offsets, emit one job.
    tbrw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_req_type  (i_req_type),
        .i_area_x    (i_area_x),
        .i_area_y    (i_area_y),
        .i_area_w    (i_area_w),
        .i_area_h    (i_area_h),
        .i_pattern_w (r_pattern_w),
        .i_pattern_h (r_pattern_h),
        .i_scale     (r_scale),
        .o_job_push  (job_push),
        .o_job       (job_in),
        .i_job_full  (job_full)
    );

    // Hold jobs so the front can run ahead of the divider.
    tbrw_job_fifo u_job_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_job   (job_out),
        .o_empty (job_empty)
    );

    // Back: scale source sizes and hold the result for the receiver.
    tbrw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pattern_x (r_pattern_x),
        .i_pattern_y (r_pattern_y),
        .i_pattern_w (r_pattern_w),
        .i_pattern_h (r_pattern_h),
        .i_job       (job_out),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (result)
    );

    assign o_tile_valid = result.tile_valid;
    assign o_cut_x      = result.cut_x;
    assign o_cut_y      = result.cut_y;
    assign o_cut_w      = result.cut_w;
    assign o_cut_h      = result.cut_h;
    assign o_place_x    = result.place_x;
    assign o_place_y    = result.place_y;
    assign o_place_w    = result.place_w;
    assign o_place_h    = result.place_h;
    assign o_last_tile  = result.last_tile;

endmodule

// ===== rtl/tbrw_checker.sv =====
// Port-level checks of the tiled blit rectangle walker, bound to its top.
// Depends on tbrw_pkg and tiled_blit_rectangle_walker_core_defines.svh.
`include "tiled_blit_rectangle_walker_core_defines.svh"

module tbrw_checker
    import tbrw_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  push,
    input logic                  full,
    input logic                  empty,
    input logic                  pop,
    input logic                  o_tile_valid,
    input logic [COORD_BITS-1:0] o_cut_x,
    input logic [COORD_BITS-1:0] o_cut_y,
    input logic [COORD_BITS-1:0] o_cut_w,
    input logic [COORD_BITS-1:0] o_cut_h,
    input logic [POS_BITS-1:0]   o_place_x,
    input logic [POS_BITS-1:0]   o_place_y,
    input logic [COORD_BITS-1:0] o_place_w,
    input logic [COORD_BITS-1:0] o_place_h,
    input logic                  o_last_tile
);

    `TBRW_ASSERT_RESET(a_reset_clear, empty && !full, "queues not clear after reset")

    `TBRW_ASSERT_NEXT(a_busy_after_accept, push && !full, full,
        "front took a second item while still working")

    `TBRW_ASSERT_NOW(a_invalid_zero, !empty && !o_tile_valid,
        o_cut_x == '0 && o_cut_y == '0 && o_cut_w == '0 && o_cut_h == '0 &&
        o_place_x == '0 && o_place_y == '0 && o_place_w == '0 && o_place_h == '0 &&
        !o_last_tile, "result without a tile carries non-zero fields")

    `TBRW_ASSERT_NOW(a_last_is_tile, !empty && o_last_tile, o_tile_valid,
        "last tile flagged on a result without a tile")

    `TBRW_ASSERT_NEXT(a_stall_hold, !empty && !pop,
        !empty && $stable(o_place_x) && $stable(o_cut_w),
        "stalled result changed")

endmodule

bind tiled_blit_rectangle_walker_core tbrw_checker u_tbrw_checker (.*);
